FILE: design/frsnl_pkg.sv
`default_nettype none

package frsnl_pkg;

  localparam int FRAC_BITS_DEF = 15;

  localparam int VEC_W = 16;
  localparam int IDX_W = 16;
  localparam int IO_W  = 16;
  localparam int DEN_W = 32;

  localparam logic [IDX_W-1:0] IDX_ONE = 16'd4096;
  localparam logic [IO_W-1:0]  IO_ONE  = 16'd32768;

  // Rounding shift to the Q1.15 output is 2*frac - IO_FRAC + 1.
  localparam int IO_FRAC = 15;

endpackage

`default_nettype wire

FILE: design/frsnl_isqrt.sv
`default_nettype none

// Pipelined floor square root, one result bit per stage.
module frsnl_isqrt #(
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [RW-1:0]   root_d [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [2*RW-1:0] rad_d  [RW];
  logic [SW-1:0]   side_q [RW];
  logic [RW-1:0]   vld_q;

  always_comb begin
    logic [RW+1:0]   prem;
    logic [RW-1:0]   proot;
    logic [2*RW-1:0] prad;
    logic [RW+1:0]   r2;
    logic [RW+1:0]   trial;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        prem  = '0;
        proot = '0;
        prad  = rad_i;
      end else begin
        prem  = rem_q[s-1];
        proot = root_q[s-1];
        prad  = rad_q[s-1];
      end
      // The partial remainder stays below 2^(s+1), so its low bits carry it.
      r2    = {prem[RW-1:0], prad[2*RW-1 -: 2]};
      trial = {proot, 2'b01};
      if (r2 >= trial) begin
        rem_d[s]  = r2 - trial;
        root_d[s] = {proot[RW-2:0], 1'b1};
      end else begin
        rem_d[s]  = r2;
        root_d[s] = {proot[RW-2:0], 1'b0};
      end
      rad_d[s] = {prad[2*RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < RW; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

FILE: design/frsnl_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The caller
// supplies the upper dividend bits as the starting remainder, which must
// be below the divisor for the quotient to fit in QW bits.
module frsnl_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] rem_d  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] low_d  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [QW-1:0] quo_d  [QW];
  logic [DW-1:0] dvs_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  always_comb begin
    logic [DW-1:0] prem;
    logic [QW-1:0] plow;
    logic [QW-1:0] pquo;
    logic [DW-1:0] pdvs;
    logic [DW:0]   r2;
    logic [DW:0]   dif;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        prem = rem_i;
        plow = low_i;
        pquo = '0;
        pdvs = dvs_i;
      end else begin
        prem = rem_q[s-1];
        plow = low_q[s-1];
        pquo = quo_q[s-1];
        pdvs = dvs_q[s-1];
      end
      r2  = {prem, plow[QW-1]};
      dif = r2 - {1'b0, pdvs};
      if (r2 >= {1'b0, pdvs}) begin
        rem_d[s] = dif[DW-1:0];
        quo_d[s] = {pquo[QW-2:0], 1'b1};
      end else begin
        rem_d[s] = r2[DW-1:0];
        quo_d[s] = {pquo[QW-2:0], 1'b0};
      end
      low_d[s] = {plow[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_d[s];
        quo_q[s]  <= quo_d[s];
        dvs_q[s]  <= (s == 0) ? dvs_i : dvs_q[s-1];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

FILE: design/fresnel_reflectance.sv
// Fresnel reflectance of a dielectric surface for unpolarized light.
// The input channel (in_valid_i / in_ready_o) carries an incident direction
// and a surface normal as signed Q1.15 vectors and the material index as
// unsigned Q4.12. The output channel (out_valid_o / out_ready_i) returns
// one transaction per input: the reflectance in unsigned Q1.15 and a flag
// for total internal reflection.
// The two square-root pipelines and the divider pipelines, one result bit
// per stage each, make up most of the pipeline. A new transaction is
// accepted in every cycle while the output register is not stalled.
// The whole pipeline advances as one: while the output register holds a
// result that the receiver does not take, every stage holds and in_ready_o
// is low, so nothing is dropped or repeated.
// Reset clears all valid bits; the output channel is empty after reset.
`default_nettype none

module fresnel_reflectance #(
  parameter int FRAC_BITS = frsnl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  incident_x_i,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  incident_y_i,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  incident_z_i,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  normal_x_i,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  normal_y_i,
  input  logic signed [frsnl_pkg::VEC_W-1:0]  normal_z_i,
  input  logic        [frsnl_pkg::IDX_W-1:0]  index_ratio_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [frsnl_pkg::IO_W-1:0]   reflectance_o,
  output logic                                total_internal_o
);

  import frsnl_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int RW   = F + 1;
  localparam int SH   = 30 - F;
  localparam int PW   = IDX_W + RW;
  localparam int XW   = (PW > DEN_W) ? PW : DEN_W;
  localparam int LW   = ($clog2(PW + 2) > 6) ? $clog2(PW + 2) : 6;
  localparam int SH2  = 2 * F - IO_FRAC + 1;
  localparam int SW1  = RW + 2 * IDX_W;
  localparam int SW2  = SW1 + 1;
  localparam int RND1 = (SH > 0) ? (1 << (SH - 1)) : 0;

  localparam logic [RW-1:0]   ONE  = RW'(1) << F;
  localparam logic [2*RW-1:0] ONE2 = (2*RW)'(1) << (2 * F);
  localparam logic [2*RW+1:0] RND2 = (2*RW+2)'(1) << (SH2 - 1);

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- front: dot product, clamp, index swap ----------------
  logic signed [31:0] p0_d, p1_d, p2_d;
  logic signed [31:0] p0_q, p1_q, p2_q;
  logic [IDX_W-1:0]   ior1_q, ior2_q;
  logic signed [33:0] d_q;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;

  assign p0_d = incident_x_i * normal_x_i;
  assign p1_d = incident_y_i * normal_y_i;
  assign p2_d = incident_z_i * normal_z_i;

  logic [RW-1:0]    c3_d, c3_q, c4_q, c5_q;
  logic [IDX_W-1:0] ein3_d, eout3_d, ein3_q, eout3_q, ein4_q, eout4_q;
  logic [IDX_W-1:0] ein5_q, eout5_q;
  logic [2*RW-1:0]  csq4_q, rad5_q;

  always_comb begin
    logic [33:0] mag;
    logic [30:0] magc;
    logic [31:0] rsum;
    logic [31:0] cfull;
    logic        pos;
    mag   = d_q[33] ? 34'(-d_q) : 34'(d_q);
    magc  = (mag > 34'(1 << 30)) ? 31'(1 << 30) : mag[30:0];
    rsum  = {1'b0, magc} + 32'(RND1);
    cfull = rsum >> SH;
    c3_d  = (cfull > 32'(ONE)) ? ONE : cfull[RW-1:0];
    // A strictly positive cosine means the ray leaves the material.
    pos   = !d_q[33] && (d_q != '0);
    ein3_d  = pos ? ior2_q : IDX_ONE;
    eout3_d = pos ? IDX_ONE : ior2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      ior1_q  <= (index_ratio_i == '0) ? IDX_W'(1) : index_ratio_i;
      d_q     <= 34'(p0_q) + 34'(p1_q) + 34'(p2_q);
      ior2_q  <= ior1_q;
      c3_q    <= c3_d;
      ein3_q  <= ein3_d;
      eout3_q <= eout3_d;
      csq4_q  <= (2*RW)'(c3_q) * (2*RW)'(c3_q);
      c4_q    <= c3_q;
      ein4_q  <= ein3_q;
      eout4_q <= eout3_q;
      rad5_q  <= ONE2 - csq4_q;
      c5_q    <= c4_q;
      ein5_q  <= ein4_q;
      eout5_q <= eout4_q;
    end
  end

  // ---------------- sine of incidence ----------------
  logic             vs1;
  logic [RW-1:0]    sini;
  logic [SW1-1:0]   side_s1;
  logic [RW-1:0]    c_s1;
  logic [IDX_W-1:0] ein_s1, eout_s1;

  frsnl_isqrt #(.RW(RW), .SW(SW1)) u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .rad_i   (rad5_q),
    .side_i  ({c5_q, ein5_q, eout5_q}),
    .valid_o (vs1),
    .root_o  (sini),
    .side_o  (side_s1)
  );
  assign {c_s1, ein_s1, eout_s1} = side_s1;

  // ---------------- Snell: sine of transmission ----------------
  logic [PW-1:0]    prod6_q, prod7_q;
  logic [RW-1:0]    c6_q, c7_q;
  logic [IDX_W-1:0] ein6_q, eout6_q, ein7_q, eout7_q;
  logic             tir7_q, v6_q, v7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod6_q <= PW'(ein_s1) * PW'(sini);
      c6_q    <= c_s1;
      ein6_q  <= ein_s1;
      eout6_q <= eout_s1;
      // The quotient reaches one exactly when the product reaches eout << F.
      tir7_q  <= prod6_q >= (PW'(eout6_q) << F);
      prod7_q <= prod6_q;
      c7_q    <= c6_q;
      ein7_q  <= ein6_q;
      eout7_q <= eout6_q;
    end
  end

  logic             vd1;
  logic [F-1:0]     sint;
  logic [SW2-1:0]   side_d1;
  logic             tir_d1;
  logic [RW-1:0]    c_d1;
  logic [IDX_W-1:0] ein_d1, eout_d1;

  frsnl_div #(.DW(IDX_W), .QW(F), .SW(SW2)) u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v7_q),
    .rem_i   (prod7_q[F +: IDX_W]),
    .low_i   (prod7_q[F-1:0]),
    .dvs_i   (eout7_q),
    .side_i  ({tir7_q, c7_q, ein7_q, eout7_q}),
    .valid_o (vd1),
    .quo_o   (sint),
    .side_o  (side_d1)
  );
  assign {tir_d1, c_d1, ein_d1, eout_d1} = side_d1;

  // ---------------- cosine of transmission ----------------
  logic [2*F-1:0]   ssq8_q;
  logic [2*RW-1:0]  rad9_q;
  logic [RW-1:0]    c8_q, c9_q;
  logic [IDX_W-1:0] ein8_q, eout8_q, ein9_q, eout9_q;
  logic             tir8_q, tir9_q, v8_q, v9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ssq8_q  <= (2*F)'(sint) * (2*F)'(sint);
      c8_q    <= c_d1;
      ein8_q  <= ein_d1;
      eout8_q <= eout_d1;
      tir8_q  <= tir_d1;
      rad9_q  <= ONE2 - (2*RW)'(ssq8_q);
      c9_q    <= c8_q;
      ein9_q  <= ein8_q;
      eout9_q <= eout8_q;
      tir9_q  <= tir8_q;
    end
  end

  logic             vs2;
  logic [RW-1:0]    cost;
  logic [SW2-1:0]   side_s2;
  logic             tir_s2;
  logic [RW-1:0]    c_s2;
  logic [IDX_W-1:0] ein_s2, eout_s2;

  frsnl_isqrt #(.RW(RW), .SW(SW2)) u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .rad_i   (rad9_q),
    .side_i  ({tir9_q, c9_q, ein9_q, eout9_q}),
    .valid_o (vs2),
    .root_o  (cost),
    .side_o  (side_s2)
  );
  assign {tir_s2, c_s2, ein_s2, eout_s2} = side_s2;

  // ---------------- amplitude ratio operands ----------------
  function automatic logic [LW-1:0] shift_cnt(input logic [PW:0] s);
    logic [LW-1:0] len;
    len = '0;
    for (int i = 0; i <= PW; i++) begin
      if (s[i]) len = LW'(i + 1);
    end
    return (len > LW'(32)) ? len - LW'(32) : '0;
  endfunction

  // Shifts both operands by the smallest count that makes their sum fit.
  function automatic logic [2*DEN_W-1:0] fit_pair(input logic [PW-1:0] a,
                                                  input logic [PW-1:0] b,
                                                  input logic [LW-1:0] k);
    logic [XW-1:0] ah, bh, al, bl;
    logic [XW:0]   suml;
    ah   = XW'(a) >> k;
    bh   = XW'(b) >> k;
    al   = XW'(a) >> (k - LW'(1));
    bl   = XW'(b) >> (k - LW'(1));
    suml = (XW+1)'(al) + (XW+1)'(bl);
    if ((k != '0) && (suml <= (XW+1)'(32'hFFFF_FFFF))) begin
      return {al[DEN_W-1:0], bl[DEN_W-1:0]};
    end
    return {ah[DEN_W-1:0], bh[DEN_W-1:0]};
  endfunction

  logic [PW-1:0]    as10_q, bs10_q, ap10_q, bp10_q;
  logic [PW-1:0]    as11_q, bs11_q, ap11_q, bp11_q;
  logic [PW-1:0]    as12_q, bs12_q, ap12_q, bp12_q;
  logic [PW:0]      ss11_q, sp11_q;
  logic [LW-1:0]    ks12_q, kp12_q;
  logic [DEN_W-1:0] as13_q, bs13_q, ap13_q, bp13_q;
  logic [DEN_W-1:0] dfs14_q, dns14_q, dfp14_q, dnp14_q;
  logic             zs14_q, zp14_q;
  logic             tir10_q, tir11_q, tir12_q, tir13_q, tir14_q;
  logic             v10_q, v11_q, v12_q, v13_q, v14_q;
  logic [DEN_W:0]   dens_w, denp_w;

  assign dens_w = (DEN_W+1)'(as13_q) + (DEN_W+1)'(bs13_q);
  assign denp_w = (DEN_W+1)'(ap13_q) + (DEN_W+1)'(bp13_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      as10_q  <= PW'(eout_s2) * PW'(c_s2);
      bs10_q  <= PW'(ein_s2) * PW'(cost);
      ap10_q  <= PW'(ein_s2) * PW'(c_s2);
      bp10_q  <= PW'(eout_s2) * PW'(cost);
      tir10_q <= tir_s2;
      ss11_q  <= (PW+1)'(as10_q) + (PW+1)'(bs10_q);
      sp11_q  <= (PW+1)'(ap10_q) + (PW+1)'(bp10_q);
      as11_q  <= as10_q;
      bs11_q  <= bs10_q;
      ap11_q  <= ap10_q;
      bp11_q  <= bp10_q;
      tir11_q <= tir10_q;
      ks12_q  <= shift_cnt(ss11_q);
      kp12_q  <= shift_cnt(sp11_q);
      as12_q  <= as11_q;
      bs12_q  <= bs11_q;
      ap12_q  <= ap11_q;
      bp12_q  <= bp11_q;
      tir12_q <= tir11_q;
      {as13_q, bs13_q} <= fit_pair(as12_q, bs12_q, ks12_q);
      {ap13_q, bp13_q} <= fit_pair(ap12_q, bp12_q, kp12_q);
      tir13_q <= tir12_q;
      dns14_q <= dens_w[DEN_W-1:0];
      dnp14_q <= denp_w[DEN_W-1:0];
      dfs14_q <= (as13_q >= bs13_q) ? as13_q - bs13_q : bs13_q - as13_q;
      dfp14_q <= (ap13_q >= bp13_q) ? ap13_q - bp13_q : bp13_q - ap13_q;
      zs14_q  <= dens_w == '0;
      zp14_q  <= denp_w == '0;
      tir14_q <= tir13_q;
    end
  end

  // ---------------- amplitude ratios ----------------
  logic          vds, vdp;
  logic [RW-1:0] rs, rp;
  logic [1:0]    side_ds;
  logic          side_dp;
  logic          tir_ds, zs_ds;

  frsnl_div #(.DW(DEN_W), .QW(RW), .SW(2)) u_div_rs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v14_q),
    .rem_i   ({1'b0, dfs14_q[DEN_W-1:1]}),
    .low_i   ({dfs14_q[0], {F{1'b0}}}),
    .dvs_i   (dns14_q),
    .side_i  ({tir14_q, zs14_q}),
    .valid_o (vds),
    .quo_o   (rs),
    .side_o  (side_ds)
  );
  assign {tir_ds, zs_ds} = side_ds;

  frsnl_div #(.DW(DEN_W), .QW(RW), .SW(1)) u_div_rp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v14_q),
    .rem_i   ({1'b0, dfp14_q[DEN_W-1:1]}),
    .low_i   ({dfp14_q[0], {F{1'b0}}}),
    .dvs_i   (dnp14_q),
    .side_i  (zp14_q),
    .valid_o (vdp),
    .quo_o   (rp),
    .side_o  (side_dp)
  );

  // ---------------- squares, mean, output ----------------
  logic [RW-1:0]   rsf, rpf;
  logic [2*RW-1:0] sqs15_q, sqp15_q;
  logic [2*RW:0]   sum16_q;
  logic            tir15_q, tir16_q, v15_q, v16_q;
  logic [2*RW+1:0] krnd;
  logic [IO_W-1:0] kr_d;
  logic [IO_W-1:0] refl_q;
  logic            tir_q, vout_q;

  assign rsf = (zs_ds || rs > ONE) ? ONE : rs;
  assign rpf = (side_dp || rp > ONE) ? ONE : rp;

  assign krnd = ((2*RW+2)'(sum16_q) + RND2) >> SH2;
  assign kr_d = tir16_q ? IO_ONE :
                (krnd > (2*RW+2)'(IO_ONE)) ? IO_ONE : krnd[IO_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqs15_q <= (2*RW)'(rsf) * (2*RW)'(rsf);
      sqp15_q <= (2*RW)'(rpf) * (2*RW)'(rpf);
      tir15_q <= tir_ds;
      sum16_q <= (2*RW+1)'(sqs15_q) + (2*RW+1)'(sqp15_q);
      tir16_q <= tir15_q;
      refl_q  <= kr_d;
      tir_q   <= tir16_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      v10_q  <= 1'b0;
      v11_q  <= 1'b0;
      v12_q  <= 1'b0;
      v13_q  <= 1'b0;
      v14_q  <= 1'b0;
      v15_q  <= 1'b0;
      v16_q  <= 1'b0;
      vout_q <= 1'b0;
    end else if (adv) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= vs1;
      v7_q   <= v6_q;
      v8_q   <= vd1;
      v9_q   <= v8_q;
      v10_q  <= vs2;
      v11_q  <= v10_q;
      v12_q  <= v11_q;
      v13_q  <= v12_q;
      v14_q  <= v13_q;
      v15_q  <= vds && vdp;
      v16_q  <= v15_q;
      vout_q <= v16_q;
    end
  end

  assign out_valid_o      = vout_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

endmodule

`default_nettype wire

FILE: design/frsnl_checker.sv
`default_nettype none

module frsnl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [frsnl_pkg::IO_W-1:0]   reflectance_o,
  input logic                         total_internal_o
);

  import frsnl_pkg::*;

  // A held result blocks the input side in the same cycle.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the output is stalled");

  // An offered input transaction stays offered until it is taken.
  a_in_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> in_valid_i)
    else $error("input transaction withdrawn before acceptance");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(reflectance_o)
                                       && $stable(total_internal_o)))
    else $error("output transaction changed while stalled");

  a_tir_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && total_internal_o) |-> (reflectance_o == IO_ONE))
    else $error("total internal reflection without full reflectance");

  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reflectance_o <= IO_ONE))
    else $error("reflectance above one");

endmodule

bind fresnel_reflectance frsnl_checker u_frsnl_checker (.*);

`default_nettype wire

FILE: tb/fresnel_reflectance_tb.sv
`timescale 1ns / 1ps

module fresnel_reflectance_tb;
  import frsnl_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [VEC_W-1:0] incident_x_i = '0, incident_y_i = '0, incident_z_i = '0;
  logic signed [VEC_W-1:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic [IDX_W-1:0] index_ratio_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IO_W-1:0] reflectance_o;
  logic total_internal_o;

  typedef struct packed {
    logic [IO_W-1:0] reflectance;
    logic total_internal;
  } shade_t;

  shade_t expected_shades[$];
  int error_count = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  int ready_burst = 0;

  always #5 clk_i = ~clk_i;

  fresnel_reflectance i_dut (.*);

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned amplitude_ratio(longint unsigned a, longint unsigned b);
    longint unsigned one = 64'd1 << FRAC;
    longint unsigned den, diff, r;
    while (a + b > 64'hFFFF_FFFF) begin
      a >>= 1;
      b >>= 1;
    end
    den = a + b;
    if (den == 0) return one;
    diff = (a >= b) ? a - b : b - a;
    r = (diff << FRAC) / den;
    return (r > one) ? one : r;
  endfunction

  function automatic shade_t predict_shade(
      logic signed [VEC_W-1:0] ix, iy, iz, nx, ny, nz, logic [IDX_W-1:0] ior);
    longint unsigned one = 64'd1 << FRAC;
    longint unsigned one2 = one * one;
    longint signed dot;
    longint unsigned idx, mag, c, sini, sint, cost, e_in, e_out, rs, rp, sum, kr;
    int sh;
    shade_t s;
    dot = longint'(ix) * longint'(nx) + longint'(iy) * longint'(ny)
        + longint'(iz) * longint'(nz);
    idx = (ior == 0) ? 1 : longint'(ior);
    mag = (dot < 0) ? -dot : dot;
    if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
    sh = 30 - FRAC;
    c = (sh > 0) ? (mag + (64'd1 << (sh - 1))) >> sh : mag;
    if (c > one) c = one;
    // A positive cosine means the ray leaves the material.
    if (dot > 0) begin
      e_in = idx;
      e_out = IDX_ONE;
    end else begin
      e_in = IDX_ONE;
      e_out = idx;
    end
    sini = floor_sqrt(one2 - c * c);
    sint = (e_in * sini) / e_out;
    if (sint >= one) begin
      s.reflectance = IO_ONE;
      s.total_internal = 1'b1;
      return s;
    end
    cost = floor_sqrt(one2 - sint * sint);
    rs = amplitude_ratio(e_out * c, e_in * cost);
    rp = amplitude_ratio(e_in * c, e_out * cost);
    sum = rs * rs + rp * rp;
    sh = 2 * FRAC - IO_FRAC + 1;
    kr = (sum + (64'd1 << (sh - 1))) >> sh;
    if (kr > (64'd1 << IO_FRAC)) kr = 64'd1 << IO_FRAC;
    s.reflectance = kr[IO_W-1:0];
    s.total_internal = 1'b0;
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Predict on every input transaction, check every output transaction.
  always @(posedge clk_i) begin
    shade_t want;
    if (in_valid_i && in_ready_o)
      expected_shades.push_back(predict_shade(incident_x_i, incident_y_i, incident_z_i,
                                              normal_x_i, normal_y_i, normal_z_i,
                                              index_ratio_i));
    if (out_valid_o && out_ready_i) begin
      if (expected_shades.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_shades.pop_front();
        if (reflectance_o !== want.reflectance)
          report_mismatch("reflectance", reflectance_o, want.reflectance);
        if (total_internal_o !== want.total_internal)
          report_mismatch("total_internal", total_internal_o, want.total_internal);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (ready_burst > 0) begin
      ready_burst <= ready_burst - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= ~out_ready_i;
      ready_burst <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("fresnel_reflectance_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_ray(logic signed [VEC_W-1:0] ix, iy, iz, nx, ny, nz,
                          logic [IDX_W-1:0] ior);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    incident_x_i <= ix;
    incident_y_i <= iy;
    incident_z_i <= iz;
    normal_x_i <= nx;
    normal_y_i <= ny;
    normal_z_i <= nz;
    index_ratio_i <= ior;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic send_unit_ray(logic [IDX_W-1:0] ior);
    real th, ph, ch;
    logic signed [VEC_W-1:0] ix, iy, iz;
    th = $urandom_range(0, 31415) / 10000.0;
    ph = $urandom_range(0, 62831) / 10000.0;
    ix = VEC_W'($rtoi(32767.0 * $sin(th) * $cos(ph)));
    iy = VEC_W'($rtoi(32767.0 * $sin(th) * $sin(ph)));
    iz = VEC_W'($rtoi(32767.0 * $cos(th)));
    // Normal is a unit vector too: half the time the z axis, else a random x-z direction.
    if ($urandom_range(0, 1)) begin
      send_ray(ix, iy, iz, 0, 0, 16'sd32767, ior);
    end else begin
      ch = $urandom_range(0, 31415) / 10000.0;
      send_ray(ix, iy, iz, VEC_W'($rtoi(32767.0 * $sin(ch))), 0,
               VEC_W'($rtoi(32767.0 * $cos(ch))), ior);
    end
  endtask

  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 3))
      0: return IDX_W'($urandom_range(4096, 8192));
      1: return IDX_W'($urandom_range(1024, 4096));
      2: return IDX_W'($urandom_range(1024, 65535));
      default: return IDX_W'($urandom());
    endcase
  endfunction

  task automatic test_directed_rays();
    send_ray(0, 0, -16'sd32767, 0, 0, 16'sd32767, 16'd6144);     // head-on, entering
    send_ray(0, 0, 16'sd32767, 0, 0, 16'sd32767, 16'd6144);      // head-on, leaving
    send_ray(16'sd32767, 0, 0, 0, 0, 16'sd32767, 16'd6144);      // grazing, zero cosine
    send_ray(16'sd23170, 0, 16'sd23170, 0, 0, 16'sd32767, 16'd6144); // leaving, past critical
    send_ray(16'sd16384, 0, -16'sd28378, 0, 0, 16'sd32767, 16'd2048); // entering a thinner medium
    send_ray(0, 0, -16'sd32767, 0, 0, 16'sd32767, 16'd0);        // zero index
    send_ray(16'sd23170, 0, -16'sd23170, 0, 0, 16'sd32767, 16'd0);
    send_ray(0, 0, -16'sd32767, 0, 0, 16'sd32767, 16'hFFFF);     // largest index
    send_ray(16'sd23170, 0, 16'sd23170, 0, 0, 16'sd32767, 16'hFFFF);
    send_ray(0, 0, -16'sd32767, 0, 0, 16'sd32767, 16'd4096);     // matched index
    send_ray(16'sd16384, 0, 16'sd28378, 0, 0, 16'sd32767, 16'd4096);
    send_ray(16'sd1024, 0, -16'sd32767, 0, 0, 16'sd32767, 16'd1024);
    // Non-unit vectors push the dot product past one.
    send_ray(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
             -16'sd32768, 16'd6144);
    send_ray(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
             16'sd32767, 16'd6144);
    send_ray(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
             16'sd32767, 16'hFFFF);
    send_ray(0, 0, 0, 0, 0, 0, 16'd6144);                         // zero vectors
    send_ray(16'sd1, 0, 0, 16'sd1, 0, 0, 16'd1);                  // tiny positive dot
    send_ray(16'sd1, 0, 0, -16'sd1, 0, 0, 16'd1);
    send_ray(16'sd32767, 0, 0, 16'sd32767, 0, 0, 16'd32768);
  endtask

  task automatic test_random_rays(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        send_ray(VEC_W'($urandom()), VEC_W'($urandom()), VEC_W'($urandom()),
                 VEC_W'($urandom()), VEC_W'($urandom()), VEC_W'($urandom()),
                 IDX_W'($urandom()));
      else
        send_unit_ray(random_index());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_rays();
    test_random_rays(700);
    quiet = 1'b1;
    test_random_rays(150);
    in_valid_i <= 1'b0;
    while (expected_shades.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0)
      $display("fresnel_reflectance_tb: done, clean");
    else
      $display("fresnel_reflectance_tb: done, errors");
    $finish;
  end

endmodule
